>>> rtl/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg: shared types and constants of the windowed moving average unit
// Command codes, field widths, parameter defaults and the controller states.
// ----------------------------------------------------------------------------
package wma_pkg;

    // Parameter defaults
    localparam int WINDOW_MAX_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths
    localparam int CMD_W       = 2;
    localparam int WSIZE_W     = 5;
    localparam int COUNT_OUT_W = 5;

    // Window size after reset
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd16;

    // Command codes (code 3 is the query and only reports the current state)
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_HOLD  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

>>> rtl/windowed_moving_average_unit.sv
// The restoring divider produces one quotient bit per cycle over the SUM_W-bit running
// sum; an add passes the update state before it, a hold or query enters it directly,
// and a clear skips it. One transaction at a time: the next is taken once the result
// has moved into the output register and the unit is back in idle. Reset clears count,
// sum and ring pointer and loads the reset window size; the sample ring needs no
// clearing pass.
// ----------------------------------------------------------------------------
// windowed_moving_average_unit
// Simple moving average over a ring of recent samples held in one synchronous
// memory, with running sum, sample count and a sequential divider for the mean.
// ----------------------------------------------------------------------------
module windowed_moving_average_unit #(
    parameter int WINDOW_MAX  = wma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + wma_pkg::COUNT_OUT_W + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Configuration write channel: window_size
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wma_pkg::WSIZE_W-1:0] cfg_data,

    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,   // [SAMPLE_BITS-1:0] sample_value
    input  logic [wma_pkg::CMD_W-1:0]   s_tuser,   // [1:0] command

    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_W-1:0]            m_tdata    // average, then sample_count
);

    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    wma_pkg::state_t            state_reg, state_next;
    wma_pkg::cmd_t              cmd_reg, cmd_next;
    logic [SAMPLE_BITS-1:0]     sample_reg, sample_next;
    logic [IDX_W-1:0]           oldest_reg, oldest_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [wma_pkg::WSIZE_W-1:0] wsize_reg;
    logic [CNT_W-1:0]           div_rem_reg, div_rem_next;
    logic [SUM_W-1:0]           div_quo_reg, div_quo_next;
    logic [DCNT_W-1:0]          div_cnt_reg, div_cnt_next;
    logic [SAMPLE_BITS-1:0]     res_avg_reg, res_avg_next;
    logic [CNT_W-1:0]           res_cnt_reg, res_cnt_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]           m_tdata_reg, m_tdata_next;
    logic [SAMPLE_BITS-1:0]     rd_data_reg;

    // Sample ring memory
    logic [SAMPLE_BITS-1:0]     ring_mem [WINDOW_MAX];
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [SAMPLE_BITS-1:0]     mem_wdata;

    // Datapath helpers
    logic                       in_fire;
    logic                       out_free;
    logic [CNT_W-1:0]           eff_window;
    logic                       drop_oldest;
    logic [IDX_W-1:0]           oldest_d;
    logic [CNT_W-1:0]           count_d;
    logic [SUM_W-1:0]           sum_d;
    logic [IDX_W:0]             slot_sum;
    logic [IDX_W-1:0]           slot;
    logic [CNT_W:0]             rem_shift;
    logic                       quo_bit;
    logic [CNT_W-1:0]           rem_step;
    logic [SUM_W-1:0]           quo_step;
    logic [SAMPLE_BITS-1:0]     avg_final;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == wma_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Effective window: zero acts as one, large values saturate
    always_comb begin
        if (wsize_reg == '0) begin
            eff_window = CNT_W'(1);
        end else if (32'(wsize_reg) > 32'(WINDOW_MAX)) begin
            eff_window = CNT_W'(WINDOW_MAX);
        end else begin
            eff_window = CNT_W'(wsize_reg);
        end
    end

    // Drop of the oldest sample and slot of the new one
    always_comb begin
        drop_oldest = (count_reg >= eff_window) && (count_reg != '0);
        oldest_d    = oldest_reg;
        count_d     = count_reg;
        sum_d       = sum_reg;
        if (drop_oldest) begin
            sum_d   = sum_reg - SUM_W'(rd_data_reg);
            count_d = count_reg - CNT_W'(1);
            if (oldest_reg == IDX_W'(WINDOW_MAX - 1)) begin
                oldest_d = '0;
            end else begin
                oldest_d = oldest_reg + IDX_W'(1);
            end
        end
        slot_sum = (IDX_W + 1)'(oldest_d) + (IDX_W + 1)'(count_d);
        if (slot_sum >= (IDX_W + 1)'(WINDOW_MAX)) begin
            slot = IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW_MAX));
        end else begin
            slot = IDX_W'(slot_sum);
        end
    end

    // One restoring division step: sum / count
    always_comb begin
        rem_shift = {div_rem_reg, div_quo_reg[SUM_W-1]};
        quo_bit   = (rem_shift >= {1'b0, count_reg});
        if (quo_bit) begin
            rem_step = CNT_W'(rem_shift - {1'b0, count_reg});
        end else begin
            rem_step = rem_shift[CNT_W-1:0];
        end
        quo_step  = {div_quo_reg[SUM_W-2:0], quo_bit};
        avg_final = (count_reg == '0) ? '0 : quo_step[SAMPLE_BITS-1:0];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wma_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (wma_pkg::cmd_t'(s_tuser))
                        wma_pkg::CMD_ADD:   state_next = wma_pkg::ST_UPDATE;
                        wma_pkg::CMD_CLEAR: state_next = wma_pkg::ST_DONE;
                        default:            state_next = wma_pkg::ST_DIV;
                    endcase
                end
            end
            wma_pkg::ST_UPDATE: state_next = wma_pkg::ST_DIV;
            wma_pkg::ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = wma_pkg::ST_DONE;
                end
            end
            wma_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = wma_pkg::ST_IDLE;
                end
            end
            default: state_next = wma_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cmd_next      = cmd_reg;
        sample_next   = sample_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_cnt_next  = div_cnt_reg;
        res_avg_next  = res_avg_reg;
        res_cnt_next  = res_cnt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mem_we        = 1'b0;
        mem_waddr     = slot;
        mem_wdata     = sample_reg;

        unique case (state_reg)
            wma_pkg::ST_IDLE: begin
                if (in_fire) begin
                    cmd_next     = wma_pkg::cmd_t'(s_tuser);
                    sample_next  = s_tdata[SAMPLE_BITS-1:0];
                    div_rem_next = '0;
                    div_quo_next = sum_reg;
                    div_cnt_next = DCNT_W'(SUM_W - 1);
                    if (wma_pkg::cmd_t'(s_tuser) == wma_pkg::CMD_CLEAR) begin
                        oldest_next  = '0;
                        count_next   = '0;
                        sum_next     = '0;
                        res_avg_next = '0;
                        res_cnt_next = '0;
                    end
                end
            end
            wma_pkg::ST_UPDATE: begin
                // old sample read at acceptance is in rd_data_reg now
                mem_we       = 1'b1;
                oldest_next  = oldest_d;
                count_next   = count_d + CNT_W'(1);
                sum_next     = sum_d + SUM_W'(sample_reg);
                div_rem_next = '0;
                div_quo_next = sum_d + SUM_W'(sample_reg);
            end
            wma_pkg::ST_DIV: begin
                div_rem_next = rem_step;
                div_quo_next = quo_step;
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == '0) begin
                    res_avg_next = avg_final;
                    res_cnt_next = count_reg;
                    if (cmd_reg == wma_pkg::CMD_HOLD) begin
                        // window collapses to one entry holding the mean
                        mem_we       = 1'b1;
                        mem_waddr    = '0;
                        mem_wdata    = avg_final;
                        oldest_next  = '0;
                        count_next   = CNT_W'(1);
                        sum_next     = SUM_W'(avg_final);
                        res_cnt_next = CNT_W'(1);
                    end
                end
            end
            wma_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({wma_pkg::COUNT_OUT_W'(res_cnt_reg), res_avg_reg});
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wma_pkg::ST_IDLE;
            oldest_reg   <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            wsize_reg    <= wma_pkg::WSIZE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                wsize_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        sample_reg  <= sample_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_cnt_reg <= div_cnt_next;
        res_avg_reg <= res_avg_next;
        res_cnt_reg <= res_cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Sample ring: one write port, registered read of the oldest entry
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[oldest_reg];
    end

endmodule

>>> tb/sv/wma_result_checker.sv
// ----------------------------------------------------------------------------
// wma_result_checker: result predictor and scoreboard for the moving average
// Watches the config, input and result channels of the unit, keeps its own
// copy of the sample ring, running sum and window size, predicts the average
// and sample count for every accepted command, and compares each result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module wma_result_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] sample_value
    input  logic [1:0]  s_tuser,    // [1:0] command

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [23:0] average, [28:24] sample_count

    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [23:0] average;
        logic [4:0]  sample_count;
    } mean_result_t;

    // Shadow copy of the unit's window state
    logic [23:0]  ring_mem [wma_pkg::WINDOW_MAX_DEF];
    logic [3:0]   ring_head;
    logic [4:0]   ring_fill;
    logic [27:0]  ring_sum;
    logic [4:0]   window_limit;

    mean_result_t expected_means [$];

    // Window size zero acts as one, sizes above the ring depth saturate
    function automatic logic [4:0] usable_depth(logic [4:0] w);
        if (w == 5'd0)
            return 5'd1;
        if (w > 5'(wma_pkg::WINDOW_MAX_DEF))
            return 5'(wma_pkg::WINDOW_MAX_DEF);
        return w;
    endfunction

    function automatic logic [23:0] window_mean();
        if (ring_fill == 5'd0)
            return 24'd0;
        return 24'(ring_sum / ring_fill);
    endfunction

    task automatic empty_window();
        ring_head = '0;
        ring_fill = '0;
        ring_sum  = '0;
    endtask

    // Store one sample, retiring the oldest one first when the window is full
    task automatic store_sample(logic [23:0] v);
        logic [3:0] slot;
        if (ring_fill >= usable_depth(window_limit) && ring_fill != 5'd0) begin
            ring_sum  = ring_sum - ring_mem[ring_head];
            ring_head = ring_head + 4'd1;
            ring_fill = ring_fill - 5'd1;
        end
        slot = ring_head + ring_fill[3:0];
        ring_mem[slot] = v;
        ring_sum  = ring_sum + v;
        ring_fill = ring_fill + 5'd1;
    endtask

    // Apply one command and return the result it produces
    task automatic update_window(input wma_pkg::cmd_t cmd, input logic [23:0] sample,
                                 output mean_result_t res);
        logic [23:0] held_mean;
        case (cmd)
            wma_pkg::CMD_ADD: begin
                store_sample(sample);
            end
            wma_pkg::CMD_CLEAR: begin
                empty_window();
            end
            wma_pkg::CMD_HOLD: begin
                held_mean = window_mean();
                empty_window();
                store_sample(held_mean);
            end
            default: begin
            end
        endcase
        res.average      = window_mean();
        res.sample_count = ring_fill;
    endtask

    always @(posedge aclk) begin
        mean_result_t exp_res;
        mean_result_t new_res;
        if (!aresetn) begin
            empty_window();
            window_limit = wma_pkg::WSIZE_RESET;
            expected_means.delete();
            outstanding = 0;
        end else begin
            // Config writes must only happen while idle; the unit does not enforce it
            if (cfg_valid && cfg_ready)
                window_limit = cfg_data;

            // Result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected result transaction: average %0h count %0d",
                           m_tdata[23:0], m_tdata[28:24]);
                    mismatches = mismatches + 1;
                end else begin
                    exp_res = expected_means.pop_front();
                    if (m_tdata[23:0] !== exp_res.average) begin
                        $error("average mismatch: expected %0h, actual %0h",
                               exp_res.average, m_tdata[23:0]);
                        mismatches = mismatches + 1;
                    end
                    if (m_tdata[28:24] !== exp_res.sample_count) begin
                        $error("sample_count mismatch: expected %0d, actual %0d",
                               exp_res.sample_count, m_tdata[28:24]);
                        mismatches = mismatches + 1;
                    end
                end
            end

            // Input transaction: predict its result
            if (s_tvalid && s_tready) begin
                update_window(wma_pkg::cmd_t'(s_tuser), s_tdata, new_res);
                expected_means.push_back(new_res);
            end

            outstanding = expected_means.size();
        end
    end

endmodule

>>> tb/sv/windowed_moving_average_unit_tb.sv
// ----------------------------------------------------------------------------
// windowed_moving_average_unit_tb: stimulus and verdict for the moving average
// Drives directed corner commands and then random command phases under a
// range of window sizes, with bursty input, a stalling result sink and two
// long sink hold-offs. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module windowed_moving_average_unit_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 65;
    localparam int PHASE_COUNT  = 10;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [23:0] sample_value
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [23:0] average, [28:24] sample_count

    int mismatches;
    int outstanding;
    int holdoff_cycles = 0;
    int burst_left = 0;

    windowed_moving_average_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    wma_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Result sink: stall pattern in segments, plus a long hold-off on request
    initial begin : result_sink
        int mode;
        int seg_left;
        mode     = 0;
        seg_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_cycles > 0) begin
                m_tready = 1'b0;
                holdoff_cycles = holdoff_cycles - 1;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left = seg_left - 1;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 5) == 0);
                    default: m_tready = ((seg_left % 8) != 0);
                endcase
            end
        end
    end

    // One input transaction, with bursts and random gaps in between
    task automatic offer(input wma_pkg::cmd_t cmd, input logic [23:0] sample);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                              : $urandom_range(0, 3);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tdata  = sample;
        s_tuser  = cmd;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left = burst_left - 1;
    endtask

    // Wait until every predicted result has come back, then let the unit settle
    task automatic drain();
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_window(input logic [4:0] size);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = size;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 24'hFFFFFF;
            1:       return 24'h000000;
            2:       return 24'($urandom_range(0, 255));
            3:       return 24'hFFFFFF - 24'($urandom_range(0, 1023));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic wma_pkg::cmd_t pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return wma_pkg::CMD_ADD;
        if (r < 84)
            return wma_pkg::CMD_CLEAR;
        if (r < 92)
            return wma_pkg::CMD_HOLD;
        return wma_pkg::CMD_QUERY;
    endfunction

    // Stimulus
    initial begin : stimulus
        logic [4:0] corner_windows [4];
        logic [4:0] size;
        corner_windows = '{5'd16, 5'd1, 5'd31, 5'd0};
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = wma_pkg::CMD_ADD;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-ring query and hold, clear, field extremes
        offer(wma_pkg::CMD_QUERY, 24'h000000);
        offer(wma_pkg::CMD_HOLD,  24'hFFFFFF);
        offer(wma_pkg::CMD_CLEAR, 24'hFFFFFF);
        offer(wma_pkg::CMD_ADD,   24'hFFFFFF);
        offer(wma_pkg::CMD_ADD,   24'h000000);
        offer(wma_pkg::CMD_ADD,   24'h000001);
        offer(wma_pkg::CMD_ADD,   24'hAAAAAA);
        offer(wma_pkg::CMD_ADD,   24'h555555);
        offer(wma_pkg::CMD_HOLD,  24'h000000);
        offer(wma_pkg::CMD_QUERY, 24'h123456);
        repeat (8) offer(wma_pkg::CMD_ADD, 24'hFFFFFF);

        // Window shrunk below the count: count must stay put
        write_window(5'd2);
        offer(wma_pkg::CMD_ADD,   24'h000000);
        offer(wma_pkg::CMD_ADD,   24'hFFFFFF);
        offer(wma_pkg::CMD_CLEAR, 24'h000000);

        // Zero window acts as one sample
        write_window(5'd0);
        offer(wma_pkg::CMD_ADD,   24'h123456);
        offer(wma_pkg::CMD_ADD,   24'hFFFFFF);
        offer(wma_pkg::CMD_HOLD,  24'h000000);

        // Oversized window saturates
        write_window(5'd31);
        offer(wma_pkg::CMD_ADD,   24'h800000);

        // Random phases, corner window sizes first
        for (int p = 0; p < PHASE_COUNT; p++) begin
            size = (p < 4) ? corner_windows[p] : 5'($urandom_range(0, 31));
            write_window(size);
            if (p == 2 || p == 7)
                holdoff_cycles = 400;
            repeat (PHASE_ITEMS) offer(pick_command(), pick_sample());
        end

        drain();
        repeat (40) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
